FILE: rtl/ray_pair_triangulation_gate_core_assert.svh
// Assertion macros used by the RTL of the triangulation gate.
`ifndef RAY_PAIR_TRIANGULATION_GATE_CORE_ASSERT_SVH
`define RAY_PAIR_TRIANGULATION_GATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RPTG_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rptg assertion failed");
`define RPTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rptg assertion failed");
`else
`define RPTG_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define RPTG_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/rptg_pkg.sv
`default_nettype none
package rptg_pkg;

  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_DEGEN  = 2'd1;
  localparam logic [1:0] ST_BEHIND = 2'd2;
  localparam logic [1:0] ST_FAR    = 2'd3;

  localparam logic [2:0] REG_O1X = 3'd0;
  localparam logic [2:0] REG_O1Y = 3'd1;
  localparam logic [2:0] REG_O1Z = 3'd2;
  localparam logic [2:0] REG_O2X = 3'd3;
  localparam logic [2:0] REG_O2Y = 3'd4;
  localparam logic [2:0] REG_O2Z = 3'd5;
  localparam logic [2:0] REG_EPS = 3'd6;

  localparam int EpsWidth = 43;

  typedef struct packed {
    logic signed [15:0] dir1_x;
    logic signed [15:0] dir1_y;
    logic signed [15:0] dir1_z;
    logic signed [15:0] dir2_x;
    logic signed [15:0] dir2_y;
    logic signed [15:0] dir2_z;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [43:0] determinant;
    logic signed [43:0] scaled_param1;
    logic signed [43:0] scaled_param2;
  } out_word_t;

  typedef struct packed {
    logic [15:0]         o1x;
    logic [15:0]         o1y;
    logic [15:0]         o1z;
    logic [15:0]         o2x;
    logic [15:0]         o2y;
    logic [15:0]         o2z;
    logic [EpsWidth-1:0] eps;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/rptg_cfg_regs.sv
`default_nettype none
module rptg_cfg_regs
  import rptg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic [2:0] idx;
  logic wr;

  assign idx    = paddr[5:3];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, EpsWidth'(1)};
    end else if (wr) begin
      case (idx)
        REG_O1X: cfg_q.o1x <= pwdata[15:0];
        REG_O1Y: cfg_q.o1y <= pwdata[15:0];
        REG_O1Z: cfg_q.o1z <= pwdata[15:0];
        REG_O2X: cfg_q.o2x <= pwdata[15:0];
        REG_O2Y: cfg_q.o2y <= pwdata[15:0];
        REG_O2Z: cfg_q.o2z <= pwdata[15:0];
        REG_EPS: cfg_q.eps <= pwdata[EpsWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_O1X: prdata = {48'd0, cfg_q.o1x};
      REG_O1Y: prdata = {48'd0, cfg_q.o1y};
      REG_O1Z: prdata = {48'd0, cfg_q.o1z};
      REG_O2X: prdata = {48'd0, cfg_q.o2x};
      REG_O2Y: prdata = {48'd0, cfg_q.o2y};
      REG_O2Z: prdata = {48'd0, cfg_q.o2z};
      REG_EPS: prdata = {{(64-EpsWidth){1'b0}}, cfg_q.eps};
      default: prdata = 64'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ray_pair_triangulation_gate_core.sv
// Throughput: one word per cycle; the nine-stage pipeline stalls as a whole only
// while the output register holds a word that is stalled.
// Reset: asynchronous active low; clears stage valid bits, origins to 0 and
// det_epsilon to 1. No clearing pass.
`default_nettype none
`include "ray_pair_triangulation_gate_core_assert.svh"
module ray_pair_triangulation_gate_core
  import rptg_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_word_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  localparam int CW = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;

  function automatic logic signed [15:0] ext(input logic [15:0] v);
    logic signed [15:0] t;
    t = $signed(v << (16 - CW));
    return t >>> (16 - CW);
  endfunction

  function automatic logic signed [23:0] round12(input logic signed [34:0] x);
    logic signed [34:0] t;
    t = (x + 35'sd2048) >>> 12;
    return 24'(t);
  endfunction

  cfg_t cfg;

  rptg_cfg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  logic adv;
  logic [9:1] v_q;
  out_word_t out_q;

  assign adv         = !v_q[9] || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = v_q[9];
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[8:1], in_valid_i};
    end
  end

  // stage 0: coordinates and the dot-product terms
  logic signed [15:0] v1s [3], v2s [3], o1s [3], o2s [3];
  logic signed [16:0] dd [3], dn [3];
  always_comb begin
    o1s[0] = ext(cfg.o1x); o1s[1] = ext(cfg.o1y); o1s[2] = ext(cfg.o1z);
    o2s[0] = ext(cfg.o2x); o2s[1] = ext(cfg.o2y); o2s[2] = ext(cfg.o2z);
    v1s[0] = ext(in_word_i.dir1_x); v1s[1] = ext(in_word_i.dir1_y);
    v1s[2] = ext(in_word_i.dir1_z);
    v2s[0] = ext(in_word_i.dir2_x); v2s[1] = ext(in_word_i.dir2_y);
    v2s[2] = ext(in_word_i.dir2_z);
    for (int k = 0; k < 3; k++) begin
      dd[k] = 17'(o2s[k]) - 17'(o1s[k]);
      dn[k] = 17'(o1s[k]) - 17'(o2s[k]);
    end
  end

  logic signed [15:0] v1_1_q [3], v2_1_q [3];
  logic signed [32:0] pa1_q [3], pa2_q [3], p11_q [3], p12_q [3], p22_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        v1_1_q[k] <= v1s[k];
        v2_1_q[k] <= v2s[k];
        pa1_q[k]  <= 33'(dd[k]) * 33'(v1s[k]);
        pa2_q[k]  <= 33'(dd[k]) * 33'(v2s[k]);
        p11_q[k]  <= 33'(v1s[k]) * 33'(v1s[k]);
        p12_q[k]  <= 33'(v1s[k]) * 33'(v2s[k]);
        p22_q[k]  <= 33'(v2s[k]) * 33'(v2s[k]);
      end
    end
  end

  // stage 2: dots rounded to Q.12
  logic signed [15:0] v1_2_q [3], v2_2_q [3];
  logic signed [23:0] a1_q, a2_q, d11_q, d12_q, d22_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_2_q <= v1_1_q;
      v2_2_q <= v2_1_q;
      a1_q  <= round12(35'(pa1_q[0]) + 35'(pa1_q[1]) + 35'(pa1_q[2]));
      a2_q  <= round12(35'(pa2_q[0]) + 35'(pa2_q[1]) + 35'(pa2_q[2]));
      d11_q <= round12(35'(p11_q[0]) + 35'(p11_q[1]) + 35'(p11_q[2]));
      d12_q <= round12(35'(p12_q[0]) + 35'(p12_q[1]) + 35'(p12_q[2]));
      d22_q <= round12(35'(p22_q[0]) + 35'(p22_q[1]) + 35'(p22_q[2]));
    end
  end

  // stage 3: products for det, s1, s2
  logic signed [15:0] v1_3_q [3], v2_3_q [3];
  logic signed [47:0] m1122_q, m1212_q, ma122_q, ma212_q, ma112_q, ma211_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_3_q  <= v1_2_q;
      v2_3_q  <= v2_2_q;
      m1122_q <= 48'(d11_q) * 48'(d22_q);
      m1212_q <= 48'(d12_q) * 48'(d12_q);
      ma122_q <= 48'(a1_q) * 48'(d22_q);
      ma212_q <= 48'(a2_q) * 48'(d12_q);
      ma112_q <= 48'(a1_q) * 48'(d12_q);
      ma211_q <= 48'(a2_q) * 48'(d11_q);
    end
  end

  // stage 4: det, s1, s2
  logic signed [15:0] v1_4_q [3], v2_4_q [3];
  logic signed [47:0] det4_q, s14_q, s24_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_4_q <= v1_3_q;
      v2_4_q <= v2_3_q;
      det4_q <= m1122_q - m1212_q;
      s14_q  <= ma122_q - ma212_q;
      s24_q  <= ma112_q - ma211_q;
    end
  end

  // stage 5: closest-point difference terms and the early gates
  logic [47:0] det_mag;
  logic degen_d, behind_d;
  assign det_mag  = det4_q[47] ? 48'(-det4_q) : 48'(det4_q);
  assign degen_d  = det_mag <= {{(48-EpsWidth){1'b0}}, cfg.eps};
  assign behind_d = (s14_q == 48'sd0) || (s24_q == 48'sd0) ||
                    (s14_q[47] != det4_q[47]) || (s24_q[47] != det4_q[47]);

  logic signed [63:0] pd_q [3], ps1_q [3], ps2_q [3];
  logic signed [47:0] det5_q, s15_q, s25_q;
  logic degen5_q, behind5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pd_q[k]  <= 64'(det4_q) * 64'(dn[k]);
        ps1_q[k] <= 64'(s14_q) * 64'(v1_4_q[k]);
        ps2_q[k] <= 64'(s24_q) * 64'(v2_4_q[k]);
      end
      det5_q    <= det4_q;
      s15_q     <= s14_q;
      s25_q     <= s24_q;
      degen5_q  <= degen_d;
      behind5_q <= behind_d;
    end
  end

  // stage 6: rounded magnitudes of P1-P2 and |s1+s2|
  logic signed [63:0] diff [3];
  logic        [63:0] dmag [3];
  logic signed [47:0] ssum;
  logic [45:0] m_d [3], sm_d;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = pd_q[k] + ps1_q[k] - ps2_q[k];
      dmag[k] = diff[k][63] ? 64'(-diff[k]) : 64'(diff[k]);
      m_d[k]  = 46'((dmag[k] + 64'd2048) >> 12);
    end
    ssum = s15_q + s25_q;
    sm_d = ssum[47] ? 46'(-ssum) : 46'(ssum);
  end

  logic [45:0] m6_q [4];
  logic signed [43:0] det6_q, s16_q, s26_q;
  logic degen6_q, behind6_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) m6_q[k] <= m_d[k];
      m6_q[3]   <= sm_d;
      det6_q    <= det5_q[43:0];
      s16_q     <= s15_q[43:0];
      s26_q     <= s25_q[43:0];
      degen6_q  <= degen5_q;
      behind6_q <= behind5_q;
    end
  end

  // stage 7: squares split into 23-bit partial products
  logic [45:0] hh_q [4], hl_q [4], ll_q [4];
  logic signed [43:0] det7_q, s17_q, s27_q;
  logic degen7_q, behind7_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        hh_q[k] <= 46'(m6_q[k][45:23]) * 46'(m6_q[k][45:23]);
        hl_q[k] <= 46'(m6_q[k][45:23]) * 46'(m6_q[k][22:0]);
        ll_q[k] <= 46'(m6_q[k][22:0]) * 46'(m6_q[k][22:0]);
      end
      det7_q    <= det6_q;
      s17_q     <= s16_q;
      s27_q     <= s26_q;
      degen7_q  <= degen6_q;
      behind7_q <= behind6_q;
    end
  end

  // stage 8: |P1-P2|^2 and (s1+s2)^2
  logic [91:0] sq [4];
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq[k] = (92'(hh_q[k]) << 46) + (92'(hl_q[k]) << 24) + 92'(ll_q[k]);
    end
  end

  logic [93:0] lhs_q;
  logic [91:0] rhs_q;
  logic signed [43:0] det8_q, s18_q, s28_q;
  logic degen8_q, behind8_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lhs_q     <= 94'(sq[0]) + 94'(sq[1]) + 94'(sq[2]);
      rhs_q     <= sq[3];
      det8_q    <= det7_q;
      s18_q     <= s17_q;
      s28_q     <= s27_q;
      degen8_q  <= degen7_q;
      behind8_q <= behind7_q;
    end
  end

  // stage 9: distance compare and status priority
  logic [107:0] lhs_scaled;
  logic [1:0] status_d;
  assign lhs_scaled = 108'(lhs_q) * 108'(10000);
  always_comb begin
    if (degen8_q)                       status_d = ST_DEGEN;
    else if (behind8_q)                 status_d = ST_BEHIND;
    else if (lhs_scaled < 108'(rhs_q))  status_d = ST_ACCEPT;
    else                                status_d = ST_FAR;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.status        <= status_d;
      out_q.determinant   <= det8_q;
      out_q.scaled_param1 <= s18_q;
      out_q.scaled_param2 <= s28_q;
    end
  end

  `RPTG_ASSERT_NEXT(a_hold_on_stall, clk_i, rst_ni, !adv, v_q == $past(v_q))
  `RPTG_ASSERT_NEXT(a_stage_shift, clk_i, rst_ni, adv, v_q[9:2] == $past(v_q[8:1]))
  `RPTG_ASSERT_SAME(a_accept_nonzero, clk_i, rst_ni, v_q[9] && out_q.status == ST_ACCEPT, out_q.determinant != 44'sd0 && out_q.scaled_param1 != 44'sd0)
  `RPTG_ASSERT_SAME(a_stall_rule, clk_i, rst_ni, in_stall_o, v_q[9] && out_stall_i)

endmodule
`default_nettype wire
